// ----- sv/lpmr_pkg.sv -----
package lpmr_pkg;

   localparam int DEF_BUFFER_BYTES = 4096;
   localparam int DEF_HEADER_BYTES = 4;

   localparam int LEN_W  = 16;
   localparam int DATA_W = 8;
   localparam int CNT_W  = 14;
   localparam int STAT_W = 2;
   localparam int OP_W   = 2;
   // wide enough for a pointer plus a header plus a full length, with a sign bit
   localparam int ALU_W  = LEN_W + 3;

   localparam logic [OP_W-1:0] OP_PUSH_BEGIN = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH_DATA  = 2'd1;
   localparam logic [OP_W-1:0] OP_POP_BYTE   = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_REJECTED = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_IGNORED  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [LEN_W-1:0]  msg_len;
      logic [DATA_W-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] data_out;
      logic              last;
      logic [LEN_W-1:0]  used_bytes;
      logic [CNT_W-1:0]  msg_count;
   } rsp_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_cmd_type;

endpackage

// ----- sv/lpmr_ram.sv -----
module lpmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/lpmr_alu.sv -----
module lpmr_alu (
   input  lpmr_pkg::alu_cmd_type           cmd,
   output logic [lpmr_pkg::ALU_W-1:0]      res
);

   logic [lpmr_pkg::ALU_W-1:0] b_eff;

   // subtract as add of the complement with carry in
   assign b_eff = cmd.sub ? ~cmd.b : cmd.b;
   assign res   = cmd.a + b_eff + lpmr_pkg::ALU_W'(cmd.sub);

endmodule

// ----- sv/length_prefixed_message_ring.sv -----
// Ring buffer of length-prefixed byte messages.
// Input channel req_*: one item per beat, op selects push_begin (msg_len),
// push_data (data_in) or pop_byte. Result channel rsp_*: exactly one result
// per item with status, popped byte, last marker, used bytes and count.
// Every item is worked through by a small sequencer around one shared
// adder/subtractor, which also computes the used byte count for each result,
// and a single byte RAM with registered read. Before each result is
// registered, the used byte count is worked out in either 1 or 3 steps.
// Ignored, empty and early rejected items go straight to those steps;
// push_begin runs the 4 room checks, then is rejected or writes its
// HEADER_BYTES header bytes; push_data writes one byte; pop_byte reads
// one byte, and first reads the header when it opens a message.
// One item is in work at a time; the next beat is taken the cycle after the
// result lands in the output register. A stalled result waits in that
// register and holds the sequencer until it can be replaced.
// Reset empties the ring and closes any open push or pop; the RAM is not
// cleared and needs no clearing pass.
module length_prefixed_message_ring #(
   parameter int BUFFER_BYTES = lpmr_pkg::DEF_BUFFER_BYTES,
   parameter int HEADER_BYTES = lpmr_pkg::DEF_HEADER_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lpmr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpmr_pkg::rsp_type rsp_data
);

   localparam int PTR_W = $clog2(BUFFER_BYTES);
   localparam int PAD_W = PTR_W + 1;
   localparam int HC_W  = $clog2(HEADER_BYTES + 1);
   localparam int AW    = lpmr_pkg::ALU_W;
   localparam int LW    = lpmr_pkg::LEN_W;
   localparam int DW    = lpmr_pkg::DATA_W;
   localparam int CW    = lpmr_pkg::CNT_W;
   localparam logic [AW-1:0]    BUF_A  = AW'(BUFFER_BYTES);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(BUFFER_BYTES - 1);
   localparam logic [HC_W-1:0]  HC_LAST = HC_W'(HEADER_BYTES - 1);
   localparam logic [HC_W-1:0]  HC_ALL  = HC_W'(HEADER_BYTES);

   typedef enum logic [15:0] {
      ST_IDLE    = 16'h0001,
      ST_PB_TOT  = 16'h0002,
      ST_PB_ROOM = 16'h0004,
      ST_PB_SUM  = 16'h0008,
      ST_PB_FIT  = 16'h0010,
      ST_PB_PAD  = 16'h0020,
      ST_PB_HDR  = 16'h0040,
      ST_PD_WR   = 16'h0080,
      ST_PP_WRAP = 16'h0100,
      ST_PP_HDR  = 16'h0200,
      ST_PP_DAT  = 16'h0400,
      ST_PP_WAIT = 16'h0800,
      ST_USED1   = 16'h1000,
      ST_USED2   = 16'h2000,
      ST_USED3   = 16'h4000,
      ST_RESP    = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] cursor_ff, cursor_in;
   logic [PAD_W-1:0] pad_ff, pad_in;
   logic [CW-1:0]    stored_ff, stored_in;
   logic [LW-1:0]    push_rem_ff, push_rem_in;
   logic [LW-1:0]    pop_rem_ff, pop_rem_in;
   logic             chk_ff, chk_in;
   logic [HC_W-1:0]  hcnt_ff, hcnt_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;

   lpmr_pkg::req_type req_ff, req_in;
   lpmr_pkg::rsp_type rsp_ff, rsp_in;
   logic [AW-1:0]     tot_ff, tot_in;
   logic [AW-1:0]     acc_ff, acc_in;
   logic              tot_ge_rp_ff, tot_ge_rp_in;
   logic [LW-1:0]     hl_ff, hl_in;
   logic [lpmr_pkg::STAT_W-1:0] st_ff, st_in;
   logic [DW-1:0]     dout_ff, dout_in;
   logic              last_ff, last_in;
   logic [LW-1:0]     used_ff, used_in;

   lpmr_pkg::alu_cmd_type alu_cmd;
   logic [AW-1:0]         alu_res;

   logic             mem_we;
   logic [PTR_W-1:0] mem_waddr;
   logic [DW-1:0]    mem_wdata;
   logic             mem_re;
   logic [PTR_W-1:0] mem_raddr;
   logic [DW-1:0]    mem_rdata;

   logic             wge;
   logic             fit_ge;
   logic             used_done;
   logic [HC_W-1:0]  hidx;
   logic [LW-1:0]    hl_cap;
   logic [PTR_W-1:0] cursor_nxt;
   logic [PTR_W-1:0] rp_nxt;

   lpmr_alu u_alu (
      .cmd (alu_cmd),
      .res (alu_res)
   );

   lpmr_ram #(
      .WIDTH (DW),
      .DEPTH (BUFFER_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign wge        = (wp_ff >= rp_ff);
   assign cursor_nxt = (cursor_ff == PTR_MAX) ? '0 : cursor_ff + 1'b1;
   assign rp_nxt     = (rp_ff == PTR_MAX) ? '0 : rp_ff + 1'b1;
   assign fit_ge     = ~alu_res[AW-1];
   assign hidx       = hcnt_ff - 1'b1;

   // header byte landing from the read issued last cycle, little endian
   always_comb begin
      hl_cap = hl_ff;
      if (pend_ff) begin
         if (hidx == HC_W'(0)) begin
            hl_cap[7:0] = mem_rdata;
         end else if (hidx == HC_W'(1)) begin
            hl_cap[15:8] = mem_rdata;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      cursor_in    = cursor_ff;
      pad_in       = pad_ff;
      stored_in    = stored_ff;
      push_rem_in  = push_rem_ff;
      pop_rem_in   = pop_rem_ff;
      chk_in       = chk_ff;
      hcnt_in      = hcnt_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      tot_in       = tot_ff;
      acc_in       = acc_ff;
      tot_ge_rp_in = tot_ge_rp_ff;
      hl_in        = hl_ff;
      st_in        = st_ff;
      dout_in      = dout_ff;
      last_in      = last_ff;
      used_in      = used_ff;
      alu_cmd      = '0;
      mem_we       = 1'b0;
      mem_waddr    = cursor_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = rp_ff;
      used_done    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               st_in   = lpmr_pkg::STAT_IGNORED;
               dout_in = '0;
               last_in = 1'b0;
               chk_in  = 1'b0;
               case (req_data.op)
                  lpmr_pkg::OP_PUSH_BEGIN: begin
                     if (push_rem_ff != '0) begin
                        state_in = ST_USED1;
                     end else if (req_data.msg_len == '0 ||
                                  AW'(req_data.msg_len) >= BUF_A) begin
                        st_in    = lpmr_pkg::STAT_REJECTED;
                        state_in = ST_USED1;
                     end else begin
                        state_in = ST_PB_TOT;
                     end
                  end
                  lpmr_pkg::OP_PUSH_DATA: begin
                     state_in = (push_rem_ff == '0) ? ST_USED1 : ST_PD_WR;
                  end
                  lpmr_pkg::OP_POP_BYTE: begin
                     if (pop_rem_ff != '0) begin
                        state_in = ST_PP_DAT;
                     end else begin
                        chk_in   = 1'b1;
                        state_in = ST_USED1;
                     end
                  end
                  default: begin
                     state_in = ST_USED1;
                  end
               endcase
            end
         end
         ST_PB_TOT: begin
            alu_cmd.a = AW'(req_ff.msg_len);
            alu_cmd.b = AW'(HEADER_BYTES);
            tot_in    = alu_res;
            state_in  = ST_PB_ROOM;
         end
         ST_PB_ROOM: begin
            alu_cmd.a    = tot_ff;
            alu_cmd.b    = AW'(rp_ff);
            alu_cmd.sub  = 1'b1;
            tot_ge_rp_in = fit_ge;
            state_in     = ST_PB_SUM;
         end
         ST_PB_SUM: begin
            alu_cmd.a = AW'(wp_ff);
            alu_cmd.b = tot_ff;
            acc_in    = alu_res;
            state_in  = ST_PB_FIT;
         end
         ST_PB_FIT: begin
            alu_cmd.a   = acc_ff;
            alu_cmd.b   = wge ? BUF_A : AW'(rp_ff);
            alu_cmd.sub = 1'b1;
            if ((wge && fit_ge && tot_ge_rp_ff) || (!wge && fit_ge)) begin
               st_in    = lpmr_pkg::STAT_REJECTED;
               state_in = ST_USED1;
            end else if (wge && fit_ge) begin
               state_in = ST_PB_PAD;
            end else begin
               cursor_in = wp_ff;
               hcnt_in   = '0;
               state_in  = ST_PB_HDR;
            end
         end
         ST_PB_PAD: begin
            // gap to the end of the ring is skipped, header goes to entry zero
            alu_cmd.a   = BUF_A;
            alu_cmd.b   = AW'(wp_ff);
            alu_cmd.sub = 1'b1;
            pad_in      = alu_res[PAD_W-1:0];
            cursor_in   = '0;
            hcnt_in     = '0;
            state_in    = ST_PB_HDR;
         end
         ST_PB_HDR: begin
            mem_we = 1'b1;
            if (hcnt_ff == HC_W'(0)) begin
               mem_wdata = req_ff.msg_len[7:0];
            end else if (hcnt_ff == HC_W'(1)) begin
               mem_wdata = req_ff.msg_len[15:8];
            end
            cursor_in = cursor_nxt;
            hcnt_in   = hcnt_ff + 1'b1;
            if (hcnt_ff == HC_LAST) begin
               push_rem_in = req_ff.msg_len;
               st_in       = lpmr_pkg::STAT_OK;
               state_in    = ST_USED1;
            end
         end
         ST_PD_WR: begin
            mem_we      = 1'b1;
            mem_wdata   = req_ff.data_in;
            cursor_in   = cursor_nxt;
            push_rem_in = push_rem_ff - 1'b1;
            if (push_rem_ff == LW'(1)) begin
               wp_in     = cursor_nxt;
               stored_in = stored_ff + 1'b1;
            end
            st_in    = lpmr_pkg::STAT_OK;
            state_in = ST_USED1;
         end
         ST_PP_WRAP: begin
            alu_cmd.a = AW'(rp_ff);
            alu_cmd.b = AW'(pad_ff);
            if (alu_res == BUF_A) begin
               pad_in = '0;
               rp_in  = '0;
            end
            hcnt_in  = '0;
            hl_in    = '0;
            state_in = ST_PP_HDR;
         end
         ST_PP_HDR: begin
            hl_in = hl_cap;
            if (hcnt_ff != HC_ALL) begin
               mem_re  = 1'b1;
               rp_in   = rp_nxt;
               hcnt_in = hcnt_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pop_rem_in = (hl_cap == '0) ? LW'(1) : hl_cap;
               state_in   = ST_PP_DAT;
            end
         end
         ST_PP_DAT: begin
            mem_re     = 1'b1;
            rp_in      = rp_nxt;
            pop_rem_in = pop_rem_ff - 1'b1;
            state_in   = ST_PP_WAIT;
         end
         ST_PP_WAIT: begin
            dout_in  = mem_rdata;
            last_in  = (pop_rem_ff == '0);
            st_in    = lpmr_pkg::STAT_OK;
            state_in = ST_USED1;
         end
         ST_USED1: begin
            alu_cmd.a   = AW'(wp_ff);
            alu_cmd.b   = AW'(rp_ff);
            alu_cmd.sub = 1'b1;
            acc_in      = alu_res;
            if (wge) begin
               used_done = 1'b1;
            end else begin
               state_in = ST_USED2;
            end
         end
         ST_USED2: begin
            alu_cmd.a = acc_ff;
            alu_cmd.b = BUF_A;
            acc_in    = alu_res;
            state_in  = ST_USED3;
         end
         ST_USED3: begin
            // wrapped contents: take out the padding gap at the end
            alu_cmd.a   = acc_ff;
            alu_cmd.b   = AW'(pad_ff);
            alu_cmd.sub = 1'b1;
            acc_in      = alu_res;
            used_done   = 1'b1;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status     = st_ff;
               rsp_in.data_out   = dout_ff;
               rsp_in.last       = last_ff;
               rsp_in.used_bytes = used_ff;
               rsp_in.msg_count  = stored_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (used_done) begin
         used_in = alu_res[LW-1:0];
         if (chk_ff) begin
            // pop between messages: empty check, then open the next message
            chk_in = 1'b0;
            if (alu_res == '0) begin
               st_in    = lpmr_pkg::STAT_EMPTY;
               state_in = ST_RESP;
            end else begin
               stored_in = stored_ff - 1'b1;
               state_in  = ST_PP_WRAP;
            end
         end else begin
            state_in = ST_RESP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         cursor_ff    <= '0;
         pad_ff       <= '0;
         stored_ff    <= '0;
         push_rem_ff  <= '0;
         pop_rem_ff   <= '0;
         chk_ff       <= 1'b0;
         hcnt_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         cursor_ff    <= cursor_in;
         pad_ff       <= pad_in;
         stored_ff    <= stored_in;
         push_rem_ff  <= push_rem_in;
         pop_rem_ff   <= pop_rem_in;
         chk_ff       <= chk_in;
         hcnt_ff      <= hcnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      tot_ff       <= tot_in;
      acc_ff       <= acc_in;
      tot_ge_rp_ff <= tot_ge_rp_in;
      hl_ff        <= hl_in;
      st_ff        <= st_in;
      dout_ff      <= dout_in;
      last_ff      <= last_in;
      used_ff      <= used_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (int'(rp_ff) < BUFFER_BYTES) && (int'(wp_ff) < BUFFER_BYTES) &&
      (int'(cursor_ff) < BUFFER_BYTES))
      else $error("ring pointer out of range");

   a_pad_range: assert property (@(posedge clock) disable iff (reset)
      int'(pad_ff) < BUFFER_BYTES)
      else $error("wrap padding reaches buffer size");

   a_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PD_WR && push_rem_ff == LW'(1)) |=> (wp_ff == cursor_ff))
      else $error("commit did not move write pointer to cursor");

   a_hdr_count: assert property (@(posedge clock) disable iff (reset)
      int'(hcnt_ff) <= HEADER_BYTES)
      else $error("header byte count overrun");

endmodule
